// ===== hdl/mgx_pkg.sv =====
// shared types, magic and key constants for the magic-gated xor descrambler
package mgx_pkg;

   localparam int unsigned MagicLen = 11;
   localparam int unsigned CntW     = 4;
   localparam int unsigned PosW     = 15;
   localparam int unsigned KeyIdxW  = 7;

   localparam logic [PosW-1:0]    WRAP_POINT = 15'h7FFF;
   localparam logic [CntW-1:0]    MAGIC_LAST = 4'd10;
   localparam logic [CntW-1:0]    MAGIC_LEN  = 4'd11;

   typedef enum logic [1:0] {
      PH_MATCHING   = 2'd0,
      PH_DESCRAMBLE = 2'd1,
      PH_PASSTHRU   = 2'd2
   } phase_type;

   // one decoded item: cnt magic bytes to replay, then the tail word
   typedef struct packed {
      logic [CntW-1:0] cnt;
      logic [7:0]      tail_byte;
      logic            has_byte;
      logic            last;
      logic            descrambled;
   } plan_type;

   localparam logic [7:0] KEY_ROM [128] = '{
      8'hc3, 8'h4a, 8'hd6, 8'hca, 8'h90, 8'h67, 8'hf7, 8'h52,
      8'hd8, 8'ha1, 8'h66, 8'h62, 8'h9f, 8'h5b, 8'h09, 8'h00,
      8'hc3, 8'h5e, 8'h95, 8'h23, 8'h9f, 8'h13, 8'h11, 8'h7e,
      8'hd8, 8'h92, 8'h3f, 8'hbc, 8'h90, 8'hbb, 8'h74, 8'h0e,
      8'hc3, 8'h47, 8'h74, 8'h3d, 8'h90, 8'haa, 8'h3f, 8'h51,
      8'hd8, 8'hf4, 8'h11, 8'h84, 8'h9f, 8'hde, 8'h95, 8'h1d,
      8'hc3, 8'hc6, 8'h09, 8'hd5, 8'h9f, 8'hfa, 8'h66, 8'hf9,
      8'hd8, 8'hf0, 8'hf7, 8'ha0, 8'h90, 8'ha1, 8'hd6, 8'hf3,
      8'hc3, 8'hf3, 8'hd6, 8'ha1, 8'h90, 8'ha0, 8'hf7, 8'hf0,
      8'hd8, 8'hf9, 8'h66, 8'hfa, 8'h9f, 8'hd5, 8'h09, 8'hc6,
      8'hc3, 8'h1d, 8'h95, 8'hde, 8'h9f, 8'h84, 8'h11, 8'hf4,
      8'hd8, 8'h51, 8'h3f, 8'haa, 8'h90, 8'h3d, 8'h74, 8'h47,
      8'hc3, 8'h0e, 8'h74, 8'hbb, 8'h90, 8'hbc, 8'h3f, 8'h92,
      8'hd8, 8'h7e, 8'h11, 8'h13, 8'h9f, 8'h23, 8'h95, 8'h5e,
      8'hc3, 8'h00, 8'h09, 8'h5b, 8'h9f, 8'h62, 8'h66, 8'ha1,
      8'hd8, 8'h52, 8'hf7, 8'h67, 8'h90, 8'hca, 8'hd6, 8'h4a
   };

   function automatic logic [7:0] magic_byte(input logic [CntW-1:0] idx);
      logic [7:0] b;
      begin
         unique case (idx)
            4'd0:    b = 8'h98;
            4'd1:    b = 8'h25;
            4'd2:    b = 8'hB0;
            4'd3:    b = 8'hAC;
            4'd4:    b = 8'hE3;
            4'd5:    b = 8'h02;
            4'd6:    b = 8'h83;
            4'd7:    b = 8'h68;
            4'd8:    b = 8'hE8;
            4'd9:    b = 8'hFC;
            4'd10:   b = 8'h6C;
            default: b = 8'h00;
         endcase
         return b;
      end
   endfunction

endpackage

// ===== hdl/magic_gated_xor_descrambler.sv =====
// top level of the magic-gated xor descrambler
// Takes one byte word per cycle while req_stall is low and returns up to one result word per
// cycle while rsp_stall is low; a byte passes the input, plan and result registers. The first
// 11 bytes of a stream are held while they match the magic and produce no result; a mismatch,
// or a stream that ends early, makes the replay sequencer emit the held magic bytes plus the
// current byte one word a cycle while the output is not stalled, and the input stalls
// meanwhile. After a full match every byte is xored with the 128-byte key. A result with
// has_byte low is an end marker for a stream that held the magic only.
module magic_gated_xor_descrambler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_stream,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_has_byte,
   output logic        rsp_out_last,
   output logic        rsp_was_descrambled
);

   logic               plan_valid;
   logic               plan_ready;
   mgx_pkg::plan_type  plan;

   mgx_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .plan_valid        (plan_valid),
      .plan_ready        (plan_ready),
      .plan              (plan)
   );

   mgx_replay u_replay (
      .clock               (clock),
      .reset               (reset),
      .plan_valid          (plan_valid),
      .plan_ready          (plan_ready),
      .plan                (plan),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_has_byte        (rsp_has_byte),
      .rsp_out_last        (rsp_out_last),
      .rsp_was_descrambled (rsp_was_descrambled)
   );

endmodule

// ===== hdl/mgx_front.sv =====
// input register, stream state and per-word decode into a replay plan
module mgx_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_data_byte,
   input  logic                req_end_of_stream,
   output logic                plan_valid,
   input  logic                plan_ready,
   output mgx_pkg::plan_type   plan
);

   logic                         a_valid_ff, a_valid_in;
   logic [7:0]                   a_byte_ff;
   logic                         a_last_ff;

   mgx_pkg::phase_type           phase_ff, phase_in;
   logic [mgx_pkg::CntW-1:0]     mcount_ff, mcount_in;
   logic [mgx_pkg::PosW-1:0]     pos_ff, pos_in;
   logic                         wrap_ff, wrap_in;

   logic [mgx_pkg::CntW-1:0]     mc;
   logic                         magic_hit;
   logic                         emit;
   logic                         a_take;
   logic [mgx_pkg::PosW-1:0]     pos_inc;
   mgx_pkg::plan_type            plan_c;

   assign a_take    = a_valid_ff && (plan_ready || !emit);
   assign req_stall = a_valid_ff && !a_take;
   assign pos_inc   = pos_ff + mgx_pkg::PosW'(1);
   assign magic_hit = a_byte_ff == mgx_pkg::magic_byte(mc);

   always_comb begin
      a_valid_in = a_valid_ff;
      if (req_valid && !req_stall) begin
         a_valid_in = 1'b1;
      end else if (a_take) begin
         a_valid_in = 1'b0;
      end
   end

   always_comb begin
      mc = (mcount_ff > mgx_pkg::MAGIC_LAST) ? mgx_pkg::MAGIC_LAST : mcount_ff;
   end

   // stream state update for the held word
   always_comb begin
      phase_in  = phase_ff;
      mcount_in = mcount_ff;
      pos_in    = pos_ff;
      wrap_in   = wrap_ff;
      unique case (phase_ff)
         mgx_pkg::PH_MATCHING: begin
            if (magic_hit) begin
               if (mc == mgx_pkg::MAGIC_LAST) begin
                  phase_in  = mgx_pkg::PH_DESCRAMBLE;
                  mcount_in = mgx_pkg::MAGIC_LEN;
                  pos_in    = mgx_pkg::PosW'(mgx_pkg::MAGIC_LEN);
                  wrap_in   = 1'b0;
               end else if (!a_last_ff) begin
                  mcount_in = mc + mgx_pkg::CntW'(1);
                  pos_in    = mgx_pkg::PosW'(mc) + mgx_pkg::PosW'(1);
               end
            end else begin
               phase_in  = mgx_pkg::PH_PASSTHRU;
               mcount_in = '0;
               pos_in    = '0;
               wrap_in   = 1'b0;
            end
         end
         mgx_pkg::PH_DESCRAMBLE: begin
            if (!wrap_ff) begin
               if (pos_ff >= mgx_pkg::WRAP_POINT) begin
                  pos_in  = mgx_pkg::PosW'(1);
                  wrap_in = 1'b1;
               end else begin
                  pos_in = pos_inc;
               end
            end else begin
               pos_in = (pos_inc >= mgx_pkg::WRAP_POINT) ? '0 : pos_inc;
            end
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
      if (a_last_ff) begin
         phase_in  = mgx_pkg::PH_MATCHING;
         mcount_in = '0;
         pos_in    = '0;
         wrap_in   = 1'b0;
      end
   end

   // decode of the held word against the current stream state
   always_comb begin
      emit                = 1'b0;
      plan_c.cnt          = '0;
      plan_c.tail_byte    = a_byte_ff;
      plan_c.has_byte     = 1'b1;
      plan_c.last         = a_last_ff;
      plan_c.descrambled  = 1'b0;
      unique case (phase_ff)
         mgx_pkg::PH_MATCHING: begin
            if (magic_hit) begin
               if (mc == mgx_pkg::MAGIC_LAST) begin
                  if (a_last_ff) begin
                     emit               = 1'b1;
                     plan_c.tail_byte   = 8'h00;
                     plan_c.has_byte    = 1'b0;
                     plan_c.descrambled = 1'b1;
                  end
               end else if (a_last_ff) begin
                  emit       = 1'b1;
                  plan_c.cnt = mc;
               end
            end else begin
               emit       = 1'b1;
               plan_c.cnt = mc;
            end
         end
         mgx_pkg::PH_DESCRAMBLE: begin
            emit               = 1'b1;
            plan_c.tail_byte   = a_byte_ff ^ mgx_pkg::KEY_ROM[pos_ff[mgx_pkg::KeyIdxW-1:0]];
            plan_c.descrambled = 1'b1;
         end
         default: begin
            emit = 1'b1;
         end
      endcase
   end

   assign plan_valid = a_valid_ff && emit;
   assign plan       = plan_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         phase_ff   <= mgx_pkg::PH_MATCHING;
         mcount_ff  <= '0;
         pos_ff     <= '0;
         wrap_ff    <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         if (a_take) begin
            phase_ff  <= phase_in;
            mcount_ff <= mcount_in;
            pos_ff    <= pos_in;
            wrap_ff   <= wrap_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         a_byte_ff <= req_data_byte;
         a_last_ff <= req_end_of_stream;
      end
   end

endmodule

// ===== hdl/mgx_replay.sv =====
// replay sequencer for held magic bytes and the result word register
module mgx_replay (
   input  logic                clock,
   input  logic                reset,
   input  logic                plan_valid,
   output logic                plan_ready,
   input  mgx_pkg::plan_type   plan,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_has_byte,
   output logic                rsp_out_last,
   output logic                rsp_was_descrambled
);

   logic                         em_valid_ff, em_valid_in;
   logic [mgx_pkg::CntW-1:0]     em_idx_ff, em_idx_in;
   mgx_pkg::plan_type            em_plan_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [7:0]                   rsp_byte_ff;
   logic                         rsp_has_ff;
   logic                         rsp_last_ff;
   logic                         rsp_ds_ff;

   logic                         out_ready;
   logic                         in_replay;
   logic [7:0]                   w_byte;
   logic                         w_has;
   logic                         w_last;
   logic                         w_ds;

   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign in_replay  = em_idx_ff < em_plan_ff.cnt;
   assign plan_ready = !em_valid_ff || (out_ready && !in_replay);

   always_comb begin
      if (in_replay) begin
         w_byte = mgx_pkg::magic_byte(em_idx_ff);
         w_has  = 1'b1;
         w_last = 1'b0;
         w_ds   = 1'b0;
      end else begin
         w_byte = em_plan_ff.tail_byte;
         w_has  = em_plan_ff.has_byte;
         w_last = em_plan_ff.last;
         w_ds   = em_plan_ff.descrambled;
      end
   end

   always_comb begin
      em_valid_in = em_valid_ff;
      em_idx_in   = em_idx_ff;
      if (plan_valid && plan_ready) begin
         em_valid_in = 1'b1;
         em_idx_in   = '0;
      end else if (em_valid_ff && out_ready) begin
         if (in_replay) begin
            em_idx_in = em_idx_ff + mgx_pkg::CntW'(1);
         end else begin
            em_valid_in = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_ready) begin
         rsp_valid_in = em_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         em_valid_ff  <= 1'b0;
         em_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         em_valid_ff  <= em_valid_in;
         em_idx_ff    <= em_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (plan_valid && plan_ready) begin
         em_plan_ff <= plan;
      end
      if (out_ready && em_valid_ff) begin
         rsp_byte_ff <= w_byte;
         rsp_has_ff  <= w_has;
         rsp_last_ff <= w_last;
         rsp_ds_ff   <= w_ds;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_byte        = rsp_byte_ff;
   assign rsp_has_byte        = rsp_has_ff;
   assign rsp_out_last        = rsp_last_ff;
   assign rsp_was_descrambled = rsp_ds_ff;

`ifndef SYNTHESIS
   a_idx_bounded: assert property (@(posedge clock) disable iff (reset)
      em_valid_ff |-> em_idx_ff <= em_plan_ff.cnt)
      else $error("replay index past count");

   a_replay_continues: assert property (@(posedge clock) disable iff (reset)
      em_valid_ff && out_ready && in_replay |=> em_valid_ff)
      else $error("replay dropped before tail word");

   a_marker_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_has_ff |-> rsp_last_ff && rsp_ds_ff && rsp_byte_ff == 8'h00)
      else $error("malformed end marker");

   a_replay_plain: assert property (@(posedge clock) disable iff (reset)
      em_valid_ff && in_replay |-> !em_plan_ff.descrambled)
      else $error("replay on descrambled stream");
`endif

endmodule

// ===== verif/tb_magic_gated_xor_descrambler.sv =====
// testbench for the magic-gated xor descrambler: byte streams checked against a predictor
module tb_magic_gated_xor_descrambler;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned RANDOM_WORDS   = 50;
   localparam int unsigned REPORT_LIMIT   = 10;

   localparam logic [7:0] MAGIC_SEQ [11] = '{
      8'h98, 8'h25, 8'hB0, 8'hAC, 8'hE3, 8'h02, 8'h83, 8'h68, 8'hE8, 8'hFC, 8'h6C
   };

   localparam logic [7:0] KEY_TABLE [128] = '{
      8'hc3, 8'h4a, 8'hd6, 8'hca, 8'h90, 8'h67, 8'hf7, 8'h52,
      8'hd8, 8'ha1, 8'h66, 8'h62, 8'h9f, 8'h5b, 8'h09, 8'h00,
      8'hc3, 8'h5e, 8'h95, 8'h23, 8'h9f, 8'h13, 8'h11, 8'h7e,
      8'hd8, 8'h92, 8'h3f, 8'hbc, 8'h90, 8'hbb, 8'h74, 8'h0e,
      8'hc3, 8'h47, 8'h74, 8'h3d, 8'h90, 8'haa, 8'h3f, 8'h51,
      8'hd8, 8'hf4, 8'h11, 8'h84, 8'h9f, 8'hde, 8'h95, 8'h1d,
      8'hc3, 8'hc6, 8'h09, 8'hd5, 8'h9f, 8'hfa, 8'h66, 8'hf9,
      8'hd8, 8'hf0, 8'hf7, 8'ha0, 8'h90, 8'ha1, 8'hd6, 8'hf3,
      8'hc3, 8'hf3, 8'hd6, 8'ha1, 8'h90, 8'ha0, 8'hf7, 8'hf0,
      8'hd8, 8'hf9, 8'h66, 8'hfa, 8'h9f, 8'hd5, 8'h09, 8'hc6,
      8'hc3, 8'h1d, 8'h95, 8'hde, 8'h9f, 8'h84, 8'h11, 8'hf4,
      8'hd8, 8'h51, 8'h3f, 8'haa, 8'h90, 8'h3d, 8'h74, 8'h47,
      8'hc3, 8'h0e, 8'h74, 8'hbb, 8'h90, 8'hbc, 8'h3f, 8'h92,
      8'hd8, 8'h7e, 8'h11, 8'h13, 8'h9f, 8'h23, 8'h95, 8'h5e,
      8'hc3, 8'h00, 8'h09, 8'h5b, 8'h9f, 8'h62, 8'h66, 8'ha1,
      8'hd8, 8'h52, 8'hf7, 8'h67, 8'h90, 8'hca, 8'hd6, 8'h4a
   };

   typedef struct packed {
      logic [7:0] data;
      logic       has;
      logic       last;
      logic       descr;
   } decoded_word_type;

   logic       clock             = 1'b0;
   logic       reset             = 1'b1;
   logic       req_valid         = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte     = 8'h00;
   logic       req_end_of_stream = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall         = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_has_byte;
   logic       rsp_out_last;
   logic       rsp_was_descrambled;

   decoded_word_type             pending_words[$];
   mgx_pkg::phase_type           phase_q   = mgx_pkg::PH_MATCHING;
   logic [mgx_pkg::CntW-1:0]     matched_q = '0;
   logic [mgx_pkg::PosW-1:0]     pos_q     = '0;
   logic                         wrapped_q = 1'b0;

   int unsigned fail_count  = 0;
   int unsigned words_sent  = 0;
   int unsigned burst_left  = 0;
   int unsigned hold_cycles = 0;
   int unsigned idle_cycles = 0;

   magic_gated_xor_descrambler dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .req_end_of_stream   (req_end_of_stream),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_has_byte        (rsp_has_byte),
      .rsp_out_last        (rsp_out_last),
      .rsp_was_descrambled (rsp_was_descrambled)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
         $display("mismatch at %0t: %s", $realtime, msg);
      end
   endfunction

   function automatic void expect_word(input logic [7:0] data, input logic has,
                                       input logic last, input logic descr);
      decoded_word_type w;
      w.data  = data;
      w.has   = has;
      w.last  = last;
      w.descr = descr;
      pending_words.insert(pending_words.size(), w);
   endfunction

   function automatic void decode_byte(input logic [7:0] b, input logic eos);
      logic [mgx_pkg::CntW-1:0] mc;
      logic [6:0]               key_idx;
      int                       j;
      if (phase_q == mgx_pkg::PH_MATCHING) begin
         mc = (matched_q >= mgx_pkg::MAGIC_LEN) ? mgx_pkg::MAGIC_LAST : matched_q;
         if (b == MAGIC_SEQ[mc]) begin
            if (mc == mgx_pkg::MAGIC_LAST) begin
               phase_q   = mgx_pkg::PH_DESCRAMBLE;
               matched_q = mgx_pkg::MAGIC_LEN;
               pos_q     = mgx_pkg::PosW'(mgx_pkg::MagicLen);
               wrapped_q = 1'b0;
               if (eos) begin
                  expect_word(8'h00, 1'b0, 1'b1, 1'b1);
               end
            end else if (eos) begin
               for (j = 0; j <= int'(mc); j++) begin
                  expect_word(MAGIC_SEQ[j], 1'b1, j == int'(mc), 1'b0);
               end
            end else begin
               matched_q = mc + mgx_pkg::CntW'(1);
            end
         end else begin
            for (j = 0; j < int'(mc); j++) begin
               expect_word(MAGIC_SEQ[j], 1'b1, 1'b0, 1'b0);
            end
            expect_word(b, 1'b1, eos, 1'b0);
            phase_q   = mgx_pkg::PH_PASSTHRU;
            matched_q = '0;
         end
      end else if (phase_q == mgx_pkg::PH_DESCRAMBLE) begin
         key_idx = pos_q[6:0];
         expect_word(b ^ KEY_TABLE[key_idx], 1'b1, eos, 1'b1);
         // position runs modulo the wrap point once it has passed it
         if (!wrapped_q) begin
            if (pos_q >= mgx_pkg::WRAP_POINT) begin
               pos_q     = mgx_pkg::PosW'(1);
               wrapped_q = 1'b1;
            end else begin
               pos_q = pos_q + mgx_pkg::PosW'(1);
            end
         end else begin
            pos_q = pos_q + mgx_pkg::PosW'(1);
            if (pos_q >= mgx_pkg::WRAP_POINT) begin
               pos_q = '0;
            end
         end
      end else begin
         expect_word(b, 1'b1, eos, 1'b0);
      end
      if (eos) begin
         phase_q   = mgx_pkg::PH_MATCHING;
         matched_q = '0;
         pos_q     = '0;
         wrapped_q = 1'b0;
      end
   endfunction

   task automatic send_word(input logic [7:0] b, input logic eos);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120)
                                                : $urandom_range(1, 20);
      end
      burst_left--;
      req_valid         <= 1'b1;
      req_data_byte     <= b;
      req_end_of_stream <= eos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_byte(b, eos);
      words_sent++;
   endtask

   task automatic send_magic(input int unsigned count, input logic eos_on_final);
      int unsigned i;
      for (i = 0; i < count; i++) begin
         send_word(MAGIC_SEQ[i], eos_on_final && i == count - 1);
      end
   endtask

   task automatic send_random_bytes(input int unsigned count);
      int unsigned i;
      logic [7:0]  b;
      for (i = 0; i < count; i++) begin
         b = 8'($urandom_range(0, 255));
         send_word(b, i == count - 1);
      end
   endtask

   task automatic test_magic_only();
      send_magic(mgx_pkg::MagicLen, 1'b1);
   endtask

   task automatic test_short_stream();
      send_magic(4, 1'b1);
      send_word(8'h00, 1'b1);
   endtask

   task automatic test_mismatch();
      send_magic(mgx_pkg::MagicLen - 1, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b1);
   endtask

   task automatic test_descramble();
      send_magic(mgx_pkg::MagicLen, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'h5A, 1'b1);
   endtask

   task automatic test_output_hold();
      hold_cycles = 100;
      send_magic(mgx_pkg::MagicLen, 1'b0);
      send_random_bytes(40);
   endtask

   task automatic test_random_streams();
      int unsigned start, kind, plen, tail;
      logic [7:0]  b;
      start = words_sent;
      while (words_sent - start < RANDOM_WORDS) begin
         kind = $urandom_range(0, 9);
         if (kind < 6) begin
            tail = $urandom_range(0, 12);
            send_magic(mgx_pkg::MagicLen, tail == 0);
            if (tail != 0) send_random_bytes(tail);
         end else if (kind < 8) begin
            // broken magic at a random depth
            plen = $urandom_range(0, mgx_pkg::MagicLen - 1);
            tail = $urandom_range(0, 6);
            if (plen != 0) send_magic(plen, 1'b0);
            b = 8'($urandom_range(0, 255));
            if (b == MAGIC_SEQ[plen]) b = ~b;
            send_word(b, tail == 0);
            if (tail != 0) send_random_bytes(tail);
         end else if (kind == 8) begin
            send_magic($urandom_range(1, mgx_pkg::MagicLen - 1), 1'b1);
         end else begin
            send_random_bytes($urandom_range(1, 6));
         end
      end
   endtask

   initial begin
      int unsigned stall_mode;
      int unsigned mode_left;
      stall_mode = 0;
      mode_left  = 0;
      forever begin
         @(posedge clock);
         if (hold_cycles != 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 3);
               mode_left  = $urandom_range(20, 200);
            end
            mode_left--;
            case (stall_mode)
               0: begin
                  rsp_stall <= 1'b0;
               end
               1: begin
                  rsp_stall <= $urandom_range(0, 7) == 0;
               end
               2: begin
                  rsp_stall <= $urandom_range(0, 1) == 0;
               end
               default: begin
                  rsp_stall <= ~rsp_stall;
               end
            endcase
         end
      end
   end

   always @(posedge clock) begin
      decoded_word_type got;
      decoded_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_out_byte, rsp_has_byte, rsp_out_last, rsp_was_descrambled};
         if (pending_words.size() == 0) begin
            note_failure($sformatf("unexpected word byte=%h has=%b last=%b descr=%b",
                                   got.data, got.has, got.last, got.descr));
         end else begin
            want = pending_words.pop_front();
            if (got.data != want.data || got.has != want.has ||
                got.last != want.last || got.descr != want.descr) begin
               note_failure($sformatf({"expected byte=%h has=%b last=%b descr=%b, ",
                                       "got byte=%h has=%b last=%b descr=%b"},
                                      want.data, want.has, want.last, want.descr,
                                      got.data, got.has, got.last, got.descr));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_magic_only();
      test_short_stream();
      test_mismatch();
      test_descramble();
      test_output_hold();
      test_random_streams();
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
